// ===== design/dms_pkg.sv =====
`default_nettype none

package dms_pkg;

   // field and timer widths
   localparam int STEP_W  = 10;
   localparam int OUTC_W  = 2;
   localparam int MODE_W  = 3;
   localparam int TIMER_W = 17;
   localparam int CFG_W   = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 4;

   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [TIMER_W-1:0] timer_type;
   typedef logic [CFG_W-1:0]   cfg_type;

   // mode codes
   localparam mode_type MODE_PEACEFUL = 3'd0;
   localparam mode_type MODE_TENSE    = 3'd1;
   localparam mode_type MODE_COMBAT   = 3'd2;
   localparam mode_type MODE_VICTORY  = 3'd3;
   localparam mode_type MODE_DEFEAT   = 3'd4;

   // outcome codes
   localparam logic [OUTC_W-1:0] OUTCOME_NONE    = 2'd0;
   localparam logic [OUTC_W-1:0] OUTCOME_VICTORY = 2'd1;
   localparam logic [OUTC_W-1:0] OUTCOME_DEFEAT  = 2'd2;

   // register indexes (word address)
   localparam logic [1:0] REG_CHECK_INTERVAL = 2'd0;
   localparam logic [1:0] REG_COMBAT_RELEASE = 2'd1;
   localparam logic [1:0] REG_SETTLE         = 2'd2;

   // register reset values
   localparam cfg_type CHECK_INTERVAL_RST = 16'd2000;
   localparam cfg_type COMBAT_RELEASE_RST = 16'd10000;
   localparam cfg_type SETTLE_RST         = 16'd4000;

   localparam timer_type TIMER_MAX = {TIMER_W{1'b1}};

   // priority pick of the observed mode
   function automatic mode_type observe_mode(input logic [OUTC_W-1:0] outcome,
                                             input logic fighting,
                                             input logic contested);
      mode_type m;
      if (outcome == OUTCOME_VICTORY) begin
         m = MODE_VICTORY;
      end else if (outcome == OUTCOME_DEFEAT) begin
         m = MODE_DEFEAT;
      end else if (fighting) begin
         m = MODE_COMBAT;
      end else if (contested) begin
         m = MODE_TENSE;
      end else begin
         m = MODE_PEACEFUL;
      end
      return m;
   endfunction

   // saturating timer add
   function automatic timer_type sat_add(input timer_type a, input timer_type b);
      logic [TIMER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIMER_W] ? TIMER_MAX : s[TIMER_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/debounced_mode_selector.sv =====
// Debounced mode selector.
// Input channel (req_*): one transaction per time step, carrying the elapsed
// milliseconds and the outcome / fighting / bases_contested flags.
// Result channel (rsp_*): one transaction per adopted mode change, carrying
// the new and the previous mode. Most steps produce no result.
// Configuration: APB-style port with check interval (0x0), combat release
// dwell (0x4) and settle dwell (0x8); write only while the block is idle.
// Timing: a step is captured in an input register, evaluated against the mode
// state once the output register is free, and its result lands in the output
// register. One step per cycle is sustained unless a result waits untaken;
// the state update loop through the mode state registers sets that rate.
// Stalls: while a result waits in the output register, one more step can sit
// in the input register; req_ready drops only when both are occupied.
// Reset: synchronous, active high; registers return to their defaults, the
// mode state returns to peaceful with cleared timers, and both stages empty.
`default_nettype none

module debounced_mode_selector (
   input  wire                            clock,
   input  wire                            reset,
   // input channel
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [dms_pkg::STEP_W-1:0]     req_step_ms,
   input  wire  [dms_pkg::OUTC_W-1:0]     req_outcome,
   input  wire                            req_fighting,
   input  wire                            req_bases_contested,
   // result channel
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [dms_pkg::MODE_W-1:0]     rsp_new_mode,
   output logic [dms_pkg::MODE_W-1:0]     rsp_old_mode,
   // configuration port
   input  wire                            psel,
   input  wire                            penable,
   input  wire                            pwrite,
   input  wire  [dms_pkg::ADDR_W-1:0]     paddr,
   input  wire  [dms_pkg::DATA_W-1:0]     pwdata,
   output logic [dms_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import dms_pkg::*;

   // configuration registers
   cfg_type check_interval_ff, combat_release_ff, settle_ff;
   logic    cfg_write;

   // input stage
   logic                s1_valid_ff;
   logic [STEP_W-1:0]   s1_step_ff;
   logic [OUTC_W-1:0]   s1_outcome_ff;
   logic                s1_fighting_ff;
   logic                s1_contested_ff;

   // mode state
   timer_type check_acc_ff, check_acc_in;
   mode_type  current_ff, current_in;
   mode_type  candidate_ff, candidate_in;
   timer_type dwell_ff, dwell_in;

   // output register
   logic      rsp_valid_ff;
   mode_type  rsp_new_ff, rsp_old_ff;

   // evaluation signals
   logic      out_free, advance, sample, emit;
   timer_type acc_sum, dwell_base, dwell_sum, dwell_need;
   mode_type  seen;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_interval_ff <= CHECK_INTERVAL_RST;
         combat_release_ff <= COMBAT_RELEASE_RST;
         settle_ff         <= SETTLE_RST;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_CHECK_INTERVAL: check_interval_ff <= pwdata[CFG_W-1:0];
            REG_COMBAT_RELEASE: combat_release_ff <= pwdata[CFG_W-1:0];
            REG_SETTLE:         settle_ff         <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      unique case (paddr[3:2])
         REG_CHECK_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, check_interval_ff};
         REG_COMBAT_RELEASE: prdata = {{(DATA_W-CFG_W){1'b0}}, combat_release_ff};
         REG_SETTLE:         prdata = {{(DATA_W-CFG_W){1'b0}}, settle_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_step_ff      <= req_step_ms;
         s1_outcome_ff   <= req_outcome;
         s1_fighting_ff  <= req_fighting;
         s1_contested_ff <= req_bases_contested;
      end
   end

   // ---------------- step evaluation ----------------
   assign acc_sum = sat_add(check_acc_ff, {{(TIMER_W-STEP_W){1'b0}}, s1_step_ff});
   assign sample  = acc_sum >= {1'b0, check_interval_ff};
   assign seen    = observe_mode(s1_outcome_ff, s1_fighting_ff, s1_contested_ff);

   // a new candidate restarts its dwell
   assign dwell_base = (seen == candidate_ff) ? dwell_ff : '0;
   assign dwell_sum  = sat_add(dwell_base, acc_sum);

   // dwell threshold for the change current -> seen
   always_comb begin
      if (seen == MODE_VICTORY || seen == MODE_DEFEAT || seen == MODE_COMBAT) begin
         dwell_need = '0;
      end else if (current_ff == MODE_COMBAT) begin
         dwell_need = {1'b0, combat_release_ff};
      end else begin
         dwell_need = {1'b0, settle_ff};
      end
   end

   always_comb begin
      check_acc_in = check_acc_ff;
      current_in   = current_ff;
      candidate_in = candidate_ff;
      dwell_in     = dwell_ff;
      emit         = 1'b0;
      if (advance) begin
         if (!sample) begin
            check_acc_in = acc_sum;
         end else begin
            check_acc_in = '0;
            candidate_in = seen;
            if (seen == current_ff) begin
               dwell_in = '0;
            end else if (dwell_sum < dwell_need) begin
               dwell_in = dwell_sum;
            end else begin
               // adopt the candidate
               current_in = seen;
               dwell_in   = '0;
               emit       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_acc_ff <= '0;
         current_ff   <= MODE_PEACEFUL;
         candidate_ff <= MODE_PEACEFUL;
         dwell_ff     <= '0;
      end else begin
         check_acc_ff <= check_acc_in;
         current_ff   <= current_in;
         candidate_ff <= candidate_in;
         dwell_ff     <= dwell_in;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_new_ff <= seen;
         rsp_old_ff <= current_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_new_mode = rsp_new_ff;
   assign rsp_old_mode = rsp_old_ff;

endmodule

`default_nettype wire
